### rtl/uart_rb_pkg.sv
// Shared types and codes for the serial port ring buffer pair.
package uart_rb_pkg;

  localparam int LEVEL_W = 7;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_IRQ   = 2'd2;

  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_RX_OVERFLOW = 2'd1;
  localparam logic [1:0] EV_NEWLINE     = 2'd2;
  localparam logic [1:0] EV_TX_DONE     = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_in;
    logic       rx_flag;
    logic       tx_flag;
  } urb_in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_valid;
    logic               write_accepted;
    logic [1:0]         event_code;
    logic [LEVEL_W-1:0] rx_level;
    logic               tx_active;
  } urb_res_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } urb_cmd_t;

  typedef struct packed {
    logic res_busy;
  } urb_status_t;

endpackage

### rtl/uart_rb_ctrl.sv
// Sequencer for the ring buffer pair: capture a transaction, then commit it.
module uart_rb_ctrl
  import uart_rb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        res_ready,
  input  urb_status_t status,
  output urb_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  always_comb begin
    in_ready    = (state == IDLE);
    cmd.capture = (state == IDLE) && in_valid;
    cmd.commit  = (state == EXEC) && (!status.res_busy || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (!status.res_busy || res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_capture_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("controller did not return to idle after commit");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

endmodule

### rtl/uart_rb_datapath.sv
// Ring pointers, byte stores, event register and result register.
module uart_rb_datapath
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  urb_cmd_t    cmd,
  output urb_status_t status,
  input  urb_in_t     in_data,
  input  logic        cfg_valid,
  input  logic        cfg_data,
  output logic        res_valid,
  input  logic        res_ready,
  output urb_res_t    res_data
);

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
  localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
  localparam logic [RPW:0]   RX_SPAN = (RPW+1)'(RX_DEPTH);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RPW-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next, rx_head_inc, rx_tail_inc;
  logic [TPW-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next, tx_head_inc, tx_tail_inc;
  logic           tx_irq_on, tx_irq_on_next;
  logic           event_enable;
  urb_in_t        item;
  logic [7:0]     rx_rdata, tx_rdata;
  logic           rx_we, tx_we;
  logic [RPW:0]   rx_diff;
  urb_res_t       res_next;

  assign status.res_busy = res_valid;

  always_comb begin
    rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
    rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
    tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
    tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;

    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_irq_on_next = tx_irq_on;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    res_next       = '0;

    case (item.func)
      FUNC_WRITE: begin
        if (tx_head_inc != tx_tail) begin
          tx_we                   = 1'b1;
          tx_head_next            = tx_head_inc;
          res_next.write_accepted = 1'b1;
        end
        tx_irq_on_next = 1'b1;
      end
      FUNC_READ: begin
        if (rx_tail != rx_head) begin
          res_next.out_byte  = rx_rdata;
          res_next.out_valid = 1'b1;
          rx_tail_next       = rx_tail_inc;
        end
      end
      FUNC_IRQ: begin
        if (item.rx_flag) begin
          if (rx_head_inc == rx_tail) begin
            res_next.event_code = EV_RX_OVERFLOW;
          end else begin
            rx_we        = 1'b1;
            rx_head_next = rx_head_inc;
            if (item.byte_in == CHAR_CR || item.byte_in == CHAR_LF) begin
              res_next.event_code = EV_NEWLINE;
            end
          end
        end
        if (item.tx_flag && tx_irq_on) begin
          if (tx_tail == tx_head) begin
            res_next.event_code = EV_TX_DONE;
            tx_irq_on_next      = 1'b0;
          end else begin
            res_next.out_byte  = tx_rdata;
            res_next.out_valid = 1'b1;
            tx_tail_next       = tx_tail_inc;
          end
        end
      end
      default: ;
    endcase

    if (!event_enable) begin
      res_next.event_code = EV_NONE;
    end

    if (rx_head_next >= rx_tail_next) begin
      rx_diff = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
    end else begin
      rx_diff = {1'b0, rx_head_next} + RX_SPAN - {1'b0, rx_tail_next};
    end
    res_next.rx_level  = LEVEL_W'(rx_diff);
    res_next.tx_active = tx_irq_on_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      rx_rdata <= rx_mem[rx_tail];
      tx_rdata <= tx_mem[tx_tail];
    end
    if (cmd.commit && rx_we) begin
      rx_mem[rx_head] <= item.byte_in;
    end
    if (cmd.commit && tx_we) begin
      tx_mem[tx_head] <= item.byte_in;
    end
    if (cmd.commit) begin
      res_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      tx_irq_on    <= 1'b0;
      event_enable <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        event_enable <= cfg_data;
      end
      if (cmd.commit) begin
        rx_head   <= rx_head_next;
        rx_tail   <= rx_tail_next;
        tx_head   <= tx_head_next;
        tx_tail   <= tx_tail_next;
        tx_irq_on <= tx_irq_on_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_commit_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.capture) || $past(cmd.commit == 1'b0 && res_valid))
    else $error("commit without a captured transaction");

  a_done_clears_active: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.event_code == EV_TX_DONE |-> !res_data.tx_active)
    else $error("transmit done reported with handling still on");

  a_write_sets_active: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.write_accepted |-> res_data.tx_active)
    else $error("accepted write left transmit handling off");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    rx_head <= RX_LAST && rx_tail <= RX_LAST && tx_head <= TX_LAST && tx_tail <= TX_LAST)
    else $error("ring pointer beyond depth");

endmodule

### rtl/uart_ring_buffer_pair.sv
// Top level of the transmit and receive ring buffer pair for one serial port.
// On accept, both ring stores are read at their tail pointers into registers;
// the controller's EXEC state then commits the pointer and store updates and
// loads the result register. The commit waits while an earlier result is
// still held. Each ring holds up to depth minus one bytes, stores come up
// unwritten with no clearing pass, and the user must write the event enable
// register through cfg only while no transaction is in flight; the block
// itself does not enforce this.
module uart_ring_buffer_pair
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  urb_in_t  in_data,
  output logic     res_valid,
  input  logic     res_ready,
  output urb_res_t res_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  urb_cmd_t    cmd;
  urb_status_t status;

  assign cfg_ready = 1'b1;

  uart_rb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_ready (res_ready),
    .status    (status),
    .cmd       (cmd)
  );

  uart_rb_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
